FILE: sv/assert_macros.svh
// Assertion macros used by the top-level RTL file of the matrix inverse block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/m3i_pkg.sv
// Package with the fixed widths and sideband type of the matrix inverse block.
package m3i_pkg;
    localparam int LANES  = 9;
    localparam int QUOT_W = 32;
    localparam int INV_W  = 32;
    localparam int DET_W  = 50;

    typedef struct packed {
        logic [LANES-1:0] neg;
        logic [LANES-1:0] ovf;
        logic             sing;
        logic [DET_W-1:0] det;
    } t_side;
endpackage

FILE: sv/m3i_det.sv
// Four-stage pipeline forming the cofactors and the determinant of a 3x3 matrix.
module m3i_det import m3i_pkg::*; #(
    parameter int ELEM_WIDTH = 16,
    parameter int DW         = 50
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [ELEM_WIDTH-1:0] i_m [LANES],
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [2*ELEM_WIDTH:0] o_cof [LANES],
    output logic signed [DW-1:0]         o_det
);
    localparam int PW = 3 * ELEM_WIDTH + 1;
    localparam int SW = 3 * ELEM_WIDTH + 3;

    logic signed [2*ELEM_WIDTH-1:0] r_pa [LANES];
    logic signed [2*ELEM_WIDTH-1:0] r_pb [LANES];
    logic signed [ELEM_WIDTH-1:0]   r_ma [3];
    logic signed [ELEM_WIDTH-1:0]   r_mb [3];
    logic signed [2*ELEM_WIDTH:0]   r_cofb [LANES];
    logic signed [2*ELEM_WIDTH:0]   r_cofc [LANES];
    logic signed [2*ELEM_WIDTH:0]   r_cofd [LANES];
    logic signed [PW-1:0]           r_dp [3];
    logic signed [DW-1:0]           r_det;
    logic signed [SW-1:0]           w_sum;
    logic r_va, r_vb, r_vc, r_vd;
    logic w_rdy_a, w_rdy_b, w_rdy_c, w_rdy_d;

    assign w_rdy_d = !r_vd || i_ready;
    assign w_rdy_c = !r_vc || w_rdy_d;
    assign w_rdy_b = !r_vb || w_rdy_c;
    assign w_rdy_a = !r_va || w_rdy_b;
    assign o_ready = w_rdy_a;
    assign o_valid = r_vd;
    assign o_det   = r_det;
    assign o_cof   = r_cofd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else begin
            if (w_rdy_a) r_va <= i_valid;
            if (w_rdy_b) r_vb <= r_va;
            if (w_rdy_c) r_vc <= r_vb;
            if (w_rdy_d) r_vd <= r_vc;
        end
    end

    // Cofactor (i,j) takes the two rows and columns after i and j, cyclically.
    for (genvar gl = 0; gl < LANES; gl++) begin : g_cof
        localparam int I1 = ((gl / 3) + 1) % 3;
        localparam int I2 = ((gl / 3) + 2) % 3;
        localparam int J1 = ((gl % 3) + 1) % 3;
        localparam int J2 = ((gl % 3) + 2) % 3;

        always_ff @(posedge i_clk) begin
            if (w_rdy_a) begin
                r_pa[gl] <= i_m[I1*3+J1] * i_m[I2*3+J2];
                r_pb[gl] <= i_m[I1*3+J2] * i_m[I2*3+J1];
            end
            if (w_rdy_b) begin
                r_cofb[gl] <= (2*ELEM_WIDTH+1)'(r_pa[gl]) - (2*ELEM_WIDTH+1)'(r_pb[gl]);
            end
            if (w_rdy_c) r_cofc[gl] <= r_cofb[gl];
            if (w_rdy_d) r_cofd[gl] <= r_cofc[gl];
        end
    end

    for (genvar gj = 0; gj < 3; gj++) begin : g_row
        always_ff @(posedge i_clk) begin
            if (w_rdy_a) r_ma[gj] <= i_m[gj];
            if (w_rdy_b) r_mb[gj] <= r_ma[gj];
            if (w_rdy_c) r_dp[gj] <= PW'(r_mb[gj]) * PW'(r_cofb[gj]);
        end
    end

    assign w_sum = SW'(r_dp[0]) + SW'(r_dp[1]) + SW'(r_dp[2]);

    always_ff @(posedge i_clk) begin
        if (w_rdy_d) r_det <= w_sum[DW-1:0];
    end
endmodule

FILE: sv/m3i_prep.sv
// Stage that takes magnitudes and signs and checks each quotient for overflow.
module m3i_prep import m3i_pkg::*; #(
    parameter int ELEM_WIDTH = 16,
    parameter int FRAC_BITS  = 8,
    parameter int DW         = 50,
    parameter int NW         = 57,
    parameter int CW         = 83
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [2*ELEM_WIDTH:0] i_cof [LANES],
    input  logic signed [DW-1:0]         i_det,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [NW-1:0]                o_rem [LANES],
    output logic [QUOT_W-1:0]            o_quo [LANES],
    output logic [DW-1:0]                o_dmag,
    output t_side                        o_side
);
    logic              r_valid;
    logic [NW-1:0]     r_rem [LANES];
    logic [DW-1:0]     r_dmag;
    t_side             r_side;
    logic              w_rdy;
    logic              w_dneg;
    logic [DW-1:0]     w_dmag;
    logic [CW-1:0]     w_dlim;
    t_side             n_side;

    assign w_rdy   = !r_valid || i_ready;
    assign o_ready = w_rdy;
    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_dmag  = r_dmag;
    assign o_side  = r_side;

    assign w_dneg = i_det[DW-1];
    assign w_dmag = w_dneg ? (~i_det + 1'b1) : i_det;
    assign w_dlim = CW'(w_dmag) << QUOT_W;

    // Inverse element (i,j) divides adjugate entry (i,j), which is cofactor (j,i).
    for (genvar gl = 0; gl < LANES; gl++) begin : g_lane
        localparam int SRC = (gl % 3) * 3 + (gl / 3);
        logic                  w_aneg;
        logic [2*ELEM_WIDTH:0] w_amag;
        logic [NW-1:0]         w_num;

        assign w_aneg = i_cof[SRC][2*ELEM_WIDTH];
        assign w_amag = w_aneg ? (~i_cof[SRC] + 1'b1) : i_cof[SRC];
        assign w_num  = NW'(w_amag) << (3 * FRAC_BITS);
        assign n_side.neg[gl] = w_aneg ^ w_dneg;
        assign n_side.ovf[gl] = CW'(w_num) >= w_dlim;
        assign o_quo[gl] = '0;

        always_ff @(posedge i_clk) begin
            if (w_rdy) r_rem[gl] <= w_num;
        end
    end

    assign n_side.sing = (i_det == '0);
    assign n_side.det  = DET_W'(i_det);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_rdy) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy) begin
            r_dmag <= w_dmag;
            r_side <= n_side;
        end
    end
endmodule

FILE: sv/m3i_div_step.sv
// One restoring-division stage: settles one quotient bit for all nine lanes.
module m3i_div_step import m3i_pkg::*; #(
    parameter int DW  = 50,
    parameter int NW  = 57,
    parameter int CW  = 83,
    parameter int BIT = 31
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [NW-1:0]     i_rem [LANES],
    input  logic [QUOT_W-1:0] i_quo [LANES],
    input  logic [DW-1:0]     i_dmag,
    input  t_side             i_side,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [NW-1:0]     o_rem [LANES],
    output logic [QUOT_W-1:0] o_quo [LANES],
    output logic [DW-1:0]     o_dmag,
    output t_side             o_side
);
    logic              r_valid;
    logic [NW-1:0]     r_rem [LANES];
    logic [QUOT_W-1:0] r_quo [LANES];
    logic [DW-1:0]     r_dmag;
    t_side             r_side;
    logic              w_rdy;
    logic [CW-1:0]     w_dk;

    assign w_rdy   = !r_valid || i_ready;
    assign o_ready = w_rdy;
    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;
    assign o_dmag  = r_dmag;
    assign o_side  = r_side;
    assign w_dk    = CW'(i_dmag) << BIT;

    for (genvar gl = 0; gl < LANES; gl++) begin : g_lane
        logic          w_ge;
        logic [CW-1:0] w_diff;

        assign w_ge   = CW'(i_rem[gl]) >= w_dk;
        assign w_diff = CW'(i_rem[gl]) - w_dk;

        // The bit settled here is still clear in the incoming quotient.
        always_ff @(posedge i_clk) begin
            if (w_rdy) begin
                r_rem[gl] <= w_ge ? w_diff[NW-1:0] : i_rem[gl];
                r_quo[gl] <= i_quo[gl] | (QUOT_W'(w_ge) << BIT);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_rdy) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy) begin
            r_dmag <= i_dmag;
            r_side <= i_side;
        end
    end
endmodule

FILE: sv/matrix3_inverse.sv
// Top level of the pipelined 3x3 fixed-point matrix inverse (adjugate over determinant).
//
//  channel | valid   | stall   | word
//  --------+---------+---------+------------------------------------------------
//  input   | i_valid | o_stall | i_a_r0c0 .. i_a_r2c2
//  output  | o_valid | i_stall | o_inv_r0c0 .. o_inv_r2c2, o_determinant,
//          |         |         | o_singular, o_clipped
//
// One word may enter every cycle while nothing stalls. A word passes through four
// cofactor and determinant stages, one sign and overflow stage, the 32 quotient
// bits, each settled by its own restoring-division stage, and the output register.
// Reset clears only the stage valid bits. Each stage holds its word while the
// stage after it is full and stalled, so bubbles close up and the input keeps
// taking words until every stage is full.

`include "assert_macros.svh"

module matrix3_inverse import m3i_pkg::*; #(
    parameter int ELEM_WIDTH = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [ELEM_WIDTH-1:0] i_a_r0c0,
    input  logic signed [ELEM_WIDTH-1:0] i_a_r0c1,
    input  logic signed [ELEM_WIDTH-1:0] i_a_r0c2,
    input  logic signed [ELEM_WIDTH-1:0] i_a_r1c0,
    input  logic signed [ELEM_WIDTH-1:0] i_a_r1c1,
    input  logic signed [ELEM_WIDTH-1:0] i_a_r1c2,
    input  logic signed [ELEM_WIDTH-1:0] i_a_r2c0,
    input  logic signed [ELEM_WIDTH-1:0] i_a_r2c1,
    input  logic signed [ELEM_WIDTH-1:0] i_a_r2c2,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [INV_W-1:0]      o_inv_r0c0,
    output logic signed [INV_W-1:0]      o_inv_r0c1,
    output logic signed [INV_W-1:0]      o_inv_r0c2,
    output logic signed [INV_W-1:0]      o_inv_r1c0,
    output logic signed [INV_W-1:0]      o_inv_r1c1,
    output logic signed [INV_W-1:0]      o_inv_r1c2,
    output logic signed [INV_W-1:0]      o_inv_r2c0,
    output logic signed [INV_W-1:0]      o_inv_r2c1,
    output logic signed [INV_W-1:0]      o_inv_r2c2,
    output logic signed [DET_W-1:0]      o_determinant,
    output logic                         o_singular,
    output logic                         o_clipped
);
    // The determinant is exact up to 62 bits; wider element formats keep it
    // modulo 2^64, which is also where its sign is taken from.
    localparam int DW = (3 * ELEM_WIDTH + 2 > 64) ? 64 : 3 * ELEM_WIDTH + 2;
    // Dividend: adjugate magnitude scaled by 2^(3*FRAC_BITS).
    localparam int NW = 2 * ELEM_WIDTH + 1 + 3 * FRAC_BITS;
    // Compare width: holds the dividend and the divisor shifted by all quotient bits.
    localparam int CW = ((NW > DW + QUOT_W) ? NW : DW + QUOT_W) + 1;

    logic signed [ELEM_WIDTH-1:0]   w_m [LANES];
    logic signed [2*ELEM_WIDTH:0]   w_cof [LANES];
    logic signed [DW-1:0]           w_det;
    logic                           w_det_valid, w_det_ready, w_in_ready;

    logic [NW-1:0]     w_rem  [QUOT_W+1][LANES];
    logic [QUOT_W-1:0] w_quo  [QUOT_W+1][LANES];
    logic [DW-1:0]     w_dmag [QUOT_W+1];
    t_side             w_side [QUOT_W+1];
    logic              w_vld  [QUOT_W+1];
    logic              w_rdy  [QUOT_W+1];

    logic              r_out_valid;
    logic [INV_W-1:0]  r_inv [LANES];
    logic [DET_W-1:0]  r_det;
    logic              r_sing, r_clip;
    logic [INV_W-1:0]  n_inv [LANES];
    logic [LANES-1:0]  n_clip;
    logic              w_fin_rdy;
    t_side             w_fs;

    assign w_m[0] = i_a_r0c0;
    assign w_m[1] = i_a_r0c1;
    assign w_m[2] = i_a_r0c2;
    assign w_m[3] = i_a_r1c0;
    assign w_m[4] = i_a_r1c1;
    assign w_m[5] = i_a_r1c2;
    assign w_m[6] = i_a_r2c0;
    assign w_m[7] = i_a_r2c1;
    assign w_m[8] = i_a_r2c2;

    assign o_stall = !w_in_ready;

    m3i_det #(
        .ELEM_WIDTH(ELEM_WIDTH),
        .DW        (DW)
    ) u_det (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(w_in_ready),
        .i_m    (w_m),
        .o_valid(w_det_valid),
        .i_ready(w_det_ready),
        .o_cof  (w_cof),
        .o_det  (w_det)
    );

    m3i_prep #(
        .ELEM_WIDTH(ELEM_WIDTH),
        .FRAC_BITS (FRAC_BITS),
        .DW        (DW),
        .NW        (NW),
        .CW        (CW)
    ) u_prep (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(w_det_valid),
        .o_ready(w_det_ready),
        .i_cof  (w_cof),
        .i_det  (w_det),
        .o_valid(w_vld[0]),
        .i_ready(w_rdy[0]),
        .o_rem  (w_rem[0]),
        .o_quo  (w_quo[0]),
        .o_dmag (w_dmag[0]),
        .o_side (w_side[0])
    );

    // Quotient bits are settled from the most significant down, one per stage.
    for (genvar gs = 0; gs < QUOT_W; gs++) begin : g_div
        m3i_div_step #(
            .DW (DW),
            .NW (NW),
            .CW (CW),
            .BIT(QUOT_W - 1 - gs)
        ) u_step (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_valid(w_vld[gs]),
            .o_ready(w_rdy[gs]),
            .i_rem  (w_rem[gs]),
            .i_quo  (w_quo[gs]),
            .i_dmag (w_dmag[gs]),
            .i_side (w_side[gs]),
            .o_valid(w_vld[gs+1]),
            .i_ready(w_rdy[gs+1]),
            .o_rem  (w_rem[gs+1]),
            .o_quo  (w_quo[gs+1]),
            .o_dmag (w_dmag[gs+1]),
            .o_side (w_side[gs+1])
        );
    end

    assign w_fin_rdy      = !r_out_valid || !i_stall;
    assign w_rdy[QUOT_W]  = w_fin_rdy;
    assign w_fs           = w_side[QUOT_W];

    // Sign and saturation. A negative quotient may reach 2^31; a positive one
    // stops at 2^31-1. A quotient flagged as overflowing saturates outright,
    // and a singular matrix forces zero with no clipping.
    for (genvar gl = 0; gl < LANES; gl++) begin : g_fin
        logic [QUOT_W-1:0] w_q;
        logic              w_big;

        assign w_q   = w_quo[QUOT_W][gl];
        assign w_big = w_fs.neg[gl] ? (w_q > {1'b1, {(QUOT_W-1){1'b0}}})
                                    : w_q[QUOT_W-1];

        always_comb begin
            n_inv[gl]  = '0;
            n_clip[gl] = 1'b0;
            if (!w_fs.sing) begin
                if (w_fs.ovf[gl] || w_big) begin
                    n_clip[gl] = 1'b1;
                    n_inv[gl]  = w_fs.neg[gl] ? {1'b1, {(INV_W-1){1'b0}}}
                                              : {1'b0, {(INV_W-1){1'b1}}};
                end else begin
                    n_inv[gl]  = w_fs.neg[gl] ? (~w_q + 1'b1) : w_q;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_fin_rdy) r_inv[gl] <= n_inv[gl];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fin_rdy) begin
            r_out_valid <= w_vld[QUOT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin_rdy) begin
            r_det  <= w_fs.det;
            r_sing <= w_fs.sing;
            r_clip <= |n_clip;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_inv_r0c0    = r_inv[0];
    assign o_inv_r0c1    = r_inv[1];
    assign o_inv_r0c2    = r_inv[2];
    assign o_inv_r1c0    = r_inv[3];
    assign o_inv_r1c1    = r_inv[4];
    assign o_inv_r1c2    = r_inv[5];
    assign o_inv_r2c0    = r_inv[6];
    assign o_inv_r2c1    = r_inv[7];
    assign o_inv_r2c2    = r_inv[8];
    assign o_determinant = r_det;
    assign o_singular    = r_sing;
    assign o_clipped     = r_clip;

    // The input can only be held off when every stage, the output one too, is full.
    `CHK_IMPLY(a_stall_only_full, i_clk, i_rst_n, o_stall, o_valid, "input stalled with output empty")
    // A singular result carries a zero determinant and no clipping.
    `CHK_IMPLY(a_sing_det, i_clk, i_rst_n, o_valid && o_singular, (o_determinant == '0) && !o_clipped, "singular word with bad determinant or clip")
    // A singular result has a zero inverse on the diagonal and in the two far corners.
    `CHK_IMPLY(a_sing_zero, i_clk, i_rst_n, o_valid && o_singular, (o_inv_r0c0 == '0) && (o_inv_r1c1 == '0) && (o_inv_r2c2 == '0) && (o_inv_r0c2 == '0) && (o_inv_r2c0 == '0), "singular word with nonzero inverse")
endmodule

FILE: tb/matrix3_inverse_tb.sv
// Self-checking testbench for the pipelined 3x3 fixed-point matrix inverse.
`timescale 1ns / 1ps

module matrix3_inverse_tb;
    import m3i_pkg::*;

    localparam int EW         = 16;
    localparam int FB         = 8;
    localparam int QSHIFT     = 3 * FB;
    localparam int IDLE_LIMIT = 4000;
    localparam int HOLD_LEN   = 300;
    localparam int RAND_ITEMS = 1150;

    // One matrix, elements in row-major order, and one inverse word.
    typedef logic [8:0][EW-1:0] t_mat;
    typedef struct packed {
        logic [8:0][INV_W-1:0] inv;
        logic [DET_W-1:0]      det;
        logic                  sing;
        logic                  clip;
    } t_inv;
    typedef struct {
        t_mat a;
        bit   typed;
        t_inv want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic o_stall, o_valid, o_singular, o_clipped;
    logic signed [EW-1:0] i_a [9];
    logic signed [INV_W-1:0] o_inv [9];
    logic signed [DET_W-1:0] o_determinant;

    initial for (int k = 0; k < 9; k++) i_a[k] = '0;

    always #1 i_clk = ~i_clk;

    matrix3_inverse #(.ELEM_WIDTH(EW), .FRAC_BITS(FB)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_a_r0c0(i_a[0]), .i_a_r0c1(i_a[1]), .i_a_r0c2(i_a[2]),
        .i_a_r1c0(i_a[3]), .i_a_r1c1(i_a[4]), .i_a_r1c2(i_a[5]),
        .i_a_r2c0(i_a[6]), .i_a_r2c1(i_a[7]), .i_a_r2c2(i_a[8]),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_inv_r0c0(o_inv[0]), .o_inv_r0c1(o_inv[1]), .o_inv_r0c2(o_inv[2]),
        .o_inv_r1c0(o_inv[3]), .o_inv_r1c1(o_inv[4]), .o_inv_r1c2(o_inv[5]),
        .o_inv_r2c0(o_inv[6]), .o_inv_r2c1(o_inv[7]), .o_inv_r2c2(o_inv[8]),
        .o_determinant(o_determinant), .o_singular(o_singular), .o_clipped(o_clipped)
    );

    // Inverses still owed by the block, oldest first.
    t_inv pending_inv [$];
    int   errors = 0;
    int   words_in = 0;
    int   words_out = 0;
    int   singular_seen = 0;
    int   clipped_seen = 0;
    int   send_idle_pct = 21;
    int   recv_idle_pct = 54;
    bit   hold_req = 1'b0;
    bit   in_fire, out_fire;

    assign in_fire  = i_valid && !o_stall;
    assign out_fire = o_valid && !i_stall;

    // Adjugate over determinant, carried out in 64-bit integers; every
    // intermediate value is exact at these widths.
    function automatic t_inv invert_matrix(t_mat a);
        longint     m [3][3];
        longint     cof [3][3];
        longint     det;
        longint     adj;
        logic [63:0] det_mag, adj_mag, quot;
        logic       det_neg, adj_neg;
        t_inv       r;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                m[i][j] = $signed(a[i * 3 + j]);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                cof[i][j] = m[(i + 1) % 3][(j + 1) % 3] * m[(i + 2) % 3][(j + 2) % 3]
                          - m[(i + 1) % 3][(j + 2) % 3] * m[(i + 2) % 3][(j + 1) % 3];
        det = 0;
        for (int j = 0; j < 3; j++) det += m[0][j] * cof[0][j];
        r = '0;
        r.det  = det[DET_W-1:0];
        r.sing = (det == 0);
        det_neg = det < 0;
        det_mag = det_neg ? -det : det;
        if (!r.sing) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    adj = cof[j][i];
                    adj_neg = adj < 0;
                    adj_mag = adj_neg ? -adj : adj;
                    quot = (adj_mag << QSHIFT) / det_mag;
                    if (adj_neg != det_neg) begin
                        if (quot > 64'h8000_0000) begin
                            quot = 64'h8000_0000;
                            r.clip = 1'b1;
                        end
                        r.inv[i * 3 + j] = -quot[31:0];
                    end else begin
                        if (quot > 64'h7FFF_FFFF) begin
                            quot = 64'h7FFF_FFFF;
                            r.clip = 1'b1;
                        end
                        r.inv[i * 3 + j] = quot[31:0];
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic t_mat mk(int e0, int e1, int e2, int e3, int e4,
                                int e5, int e6, int e7, int e8);
        t_mat a;
        a[0] = EW'(e0); a[1] = EW'(e1); a[2] = EW'(e2);
        a[3] = EW'(e3); a[4] = EW'(e4); a[5] = EW'(e5);
        a[6] = EW'(e6); a[7] = EW'(e7); a[8] = EW'(e8);
        return a;
    endfunction

    function automatic int rnd_range(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    // Random matrices: the largest share well-conditioned, so that the quotient
    // stages see real values, plus raw noise, singular ones and small ones.
    function automatic t_mat random_matrix();
        t_mat a;
        int   kind;
        int   sel;
        kind = int'($urandom_range(99));
        for (int k = 0; k < 9; k++) a[k] = EW'($urandom);
        if (kind < 40) begin
            for (int k = 0; k < 9; k++) begin
                if (k % 4 == 0)
                    a[k] = EW'(($urandom_range(1) ? 1 : -1) * rnd_range(256, 32767));
                else
                    a[k] = EW'(rnd_range(-600, 600));
            end
        end else if (kind < 65) begin
            for (int k = 0; k < 9; k++) a[k] = EW'(rnd_range(-2048, 2047));
        end else if (kind < 80) begin
            // Singular: a repeated row, a zero row or a zero column.
            sel = int'($urandom_range(2));
            if (sel == 0) begin
                for (int j = 0; j < 3; j++) a[6 + j] = a[j];
            end else if (sel == 1) begin
                sel = int'($urandom_range(2));
                for (int j = 0; j < 3; j++) a[3 * sel + j] = '0;
            end else begin
                sel = int'($urandom_range(2));
                for (int i = 0; i < 3; i++) a[3 * i + sel] = '0;
            end
        end
        return a;
    endfunction

    // Directed words. Only the obvious ones carry a typed-in answer.
    t_row directed [$];

    function automatic void build_directed();
        t_row r;
        r.typed = 1'b1;
        r.a = mk(256, 0, 0, 0, 256, 0, 0, 0, 256);
        r.want = '0;
        r.want.inv[0] = 32'h0001_0000;
        r.want.inv[4] = 32'h0001_0000;
        r.want.inv[8] = 32'h0001_0000;
        r.want.det = 50'd1 << 24;
        directed.push_back(r);
        r.a = '0;
        r.want = '0;
        r.want.sing = 1'b1;
        directed.push_back(r);
        // Unit shear with a huge off-diagonal term: the inverse saturates.
        r.a = mk(1, 32767, 0, 0, 1, 0, 0, 0, 1);
        r.want = '0;
        r.want.inv[0] = 32'h0100_0000;
        r.want.inv[1] = 32'h8000_0000;
        r.want.inv[4] = 32'h0100_0000;
        r.want.inv[8] = 32'h0100_0000;
        r.want.det = 50'd1;
        r.want.clip = 1'b1;
        directed.push_back(r);
        r.typed = 1'b0;
        r.want = '0;
        r.a = mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
        directed.push_back(r);
        r.a = {9{16'h8000}};
        directed.push_back(r);
        r.a = mk(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768);
        directed.push_back(r);
        r.a = mk(32767, 0, 0, 0, 32767, 0, 0, 0, 32767);
        directed.push_back(r);
        r.a = mk(1, 0, 0, 0, 1, 0, 0, 0, 1);
        directed.push_back(r);
        r.a = mk(-1, 0, 0, 0, -1, 0, 0, 0, -1);
        directed.push_back(r);
        r.a = mk(0, 256, 0, 0, 0, 256, 256, 0, 0);
        directed.push_back(r);
        r.a = mk(-32768, 32767, 0, 32767, -32768, 32767, 0, 32767, -32768);
        directed.push_back(r);
        r.a = mk('h5555, 'hAAAA, 'h5555, 'hAAAA, 'h5555, 'hAAAA, 'h5555, 'hAAAA, 'h7FFF);
        directed.push_back(r);
        r.a = mk(1, 2, 3, 4, 5, 6, 7, 8, 9);
        directed.push_back(r);
        r.a = mk(32767, 1, 0, 0, 1, 0, 0, 0, 32767);
        directed.push_back(r);
        r.a = mk(181, -181, 0, 181, 181, 0, 0, 0, 256);
        directed.push_back(r);
        r.a = mk(-32768, 1, 1, 1, 1, 0, 1, 0, 1);
        directed.push_back(r);
    endfunction

    // Hands one word to the block, with the sender's random gaps in front.
    task automatic send_matrix(t_mat a, bit typed, t_inv want);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        for (int k = 0; k < 9; k++) i_a[k] <= a[k];
        do @(posedge i_clk); while (o_stall);
        pending_inv.push_back(typed ? want : invert_matrix(a));
        words_in++;
    endtask

    // Output side: check each word taken, then choose the next stall value.
    // A long hold-off is counted here once the sender side asks for it.
    int hold_left = 0;
    always @(posedge i_clk) begin
        t_inv exp_w;
        if (i_rst_n && out_fire) begin
            words_out++;
            if (pending_inv.size() == 0) begin
                $display("%0t: inverse word with nothing expected", $time);
                errors++;
            end else begin
                exp_w = pending_inv.pop_front();
                for (int k = 0; k < 9; k++)
                    if (o_inv[k] !== exp_w.inv[k]) begin
                        $display("%0t: inv element %0d expected %h actual %h",
                                 $time, k, exp_w.inv[k], o_inv[k]);
                        errors++;
                    end
                if (o_determinant !== exp_w.det) begin
                    $display("%0t: determinant expected %h actual %h",
                             $time, exp_w.det, o_determinant);
                    errors++;
                end
                if (o_singular !== exp_w.sing) begin
                    $display("%0t: singular expected %b actual %b",
                             $time, exp_w.sing, o_singular);
                    errors++;
                end
                if (o_clipped !== exp_w.clip) begin
                    $display("%0t: clipped expected %b actual %b",
                             $time, exp_w.clip, o_clipped);
                    errors++;
                end
                singular_seen += exp_w.sing;
                clipped_seen  += exp_w.clip;
            end
        end
        // The request is taken and cleared here, so it cannot be missed.
        if (hold_req) begin
            hold_left = HOLD_LEN;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog on cycles in which no word moves on either side.
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if (in_fire || out_fire) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_inv.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        t_inv none;
        none = '0;
        build_directed();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[n]) send_matrix(directed[n].a, directed[n].typed, directed[n].want);
        drain();

        // Phase one: sender idles a little, receiver a lot.
        for (int n = 0; n < RAND_ITEMS / 3; n++) send_matrix(random_matrix(), 1'b0, none);
        drain();

        // Phase two: the other way round.
        send_idle_pct = 54;
        recv_idle_pct = 21;
        for (int n = 0; n < RAND_ITEMS / 3; n++) send_matrix(random_matrix(), 1'b0, none);
        drain();

        // Phase three: no idling, opening with a long output hold-off so the
        // pipeline fills and pushes back on the input.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1'b1;
        for (int n = 0; n < RAND_ITEMS - 2 * (RAND_ITEMS / 3); n++)
            send_matrix(random_matrix(), 1'b0, none);
        drain();
        repeat (60) @(posedge i_clk);

        $display("Inverted %0d matrices (%0d returned): %0d singular, %0d saturated.",
                 words_in, words_out, singular_seen, clipped_seen);
        $display("Idling covered both sides, a long output hold-off and a full drain.");
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+sv
sv/m3i_pkg.sv
sv/m3i_det.sv
sv/m3i_prep.sv
sv/m3i_div_step.sv
sv/matrix3_inverse.sv
tb/matrix3_inverse_tb.sv
